// File: src/satss_pkg.sv
// Package for the stale-aware temperature source selector.
// Holds item types, cell control types, register indexes and sizing constants.
// No dependencies.
`default_nettype none
package satss_pkg;

  localparam int NUM_SOURCES   = 8;
  localparam int CH_W          = 4;
  localparam int TEMP_W        = 16;
  localparam int AGE_W         = 7;
  localparam int PRESCALE_W    = 7;
  localparam int CFG_IDX_W     = 2;

  localparam logic [AGE_W-1:0]      MAX_AGE        = AGE_W'(120);
  localparam logic [AGE_W-1:0]      AGE_STALE      = AGE_W'(121);
  localparam logic [PRESCALE_W:0]   TICKS_PER_AGE  = (PRESCALE_W+1)'(100);
  localparam logic signed [TEMP_W-1:0] TEMP_VALID_MIN = -TEMP_W'(1000);
  localparam logic signed [TEMP_W-1:0] TEMP_VALID_MAX = TEMP_W'(5500);
  localparam logic [TEMP_W-1:0]     SETPOINT_RESET = TEMP_W'(2500);

  localparam logic [CFG_IDX_W-1:0]  CFG_SOURCE_SELECT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0]  CFG_SETPOINT      = CFG_IDX_W'(1);

  localparam logic                  REQ_TICK   = 1'b0;
  localparam logic                  REQ_SAMPLE = 1'b1;

  typedef struct packed {
    logic                     req_type;
    logic [CH_W-1:0]          channel;
    logic signed [TEMP_W-1:0] sample_temp;
    logic signed [TEMP_W-1:0] fallback_temp;
  } req_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] setpoint_out;
    logic signed [TEMP_W-1:0] reference_temp;
    logic                     used_fallback;
  } rsp_t;

  typedef struct packed {
    logic                     load;
    logic [CH_W-1:0]          channel;
    logic signed [TEMP_W-1:0] sample;
    logic                     age_step;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] value;
    logic                     stale;
  } tap_t;

endpackage
`default_nettype wire

// File: src/satss_cell.sv
// One sensor channel cell: latest value and age counter.
// Passes the selected channel's tap along the chain. Depends on satss_pkg.
`default_nettype none
module satss_cell
  import satss_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [CH_W-1:0] idx,
  input  wire logic [CH_W-1:0] sel,
  input  wire cell_ctl_t       ctl,
  input  wire tap_t            tap_in,
  output tap_t                 tap_out
);

  logic signed [TEMP_W-1:0] value;
  logic [AGE_W-1:0]         age;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      age   <= AGE_STALE;
    end else if (ctl.load && ctl.channel == idx) begin
      value <= ctl.sample;
      age   <= '0;
    end else if (ctl.age_step && age <= MAX_AGE) begin
      age <= age + AGE_W'(1);
    end
  end

  always_comb begin
    if (sel == idx) begin
      tap_out.value = value;
      tap_out.stale = age > MAX_AGE;
    end else begin
      tap_out = tap_in;
    end
  end

  a_age_bound: assert property (@(posedge clk) disable iff (rst) age <= AGE_STALE)
    else $error("cell age beyond stale mark");

endmodule
`default_nettype wire

// File: src/stale_aware_temperature_source_select.sv
// Top level of the stale-aware temperature source selector.
// Instantiates the row of satss_cell channel cells; depends on satss_pkg.
//
// Usage:
//   req channel: req_valid/req_stall carry one req_t item, a time tick or a
//   temperature sample. An item is taken when req_valid is high and
//   req_stall is low.
//   rsp channel: rsp_valid/rsp_stall carry one rsp_t item per request with
//   the setpoint and the reference temperature after that request.
//   cfg channel: cfg_valid/cfg_ready write source_select (index 0) or
//   setpoint (index 1); cfg_ready is always high. Write only while idle.
// Timing: one request per cycle sustained while rsp_stall is low. When a request
//   is taken, the channel cells update and the item enters the pending stage;
//   the selection chain is walked into the result register once the output can advance.
// Reset: rst is synchronous; all channels go stale with value zero, the
//   prescaler clears, source_select is 0 and setpoint is 2500.
// Stall: with rsp_stall high the result holds; one more request is taken
//   into the pending stage, then req_stall rises until the result drains.
`default_nettype none
module stale_aware_temperature_source_select
  import satss_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire req_t                 req,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output rsp_t                      rsp,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TEMP_W-1:0]    cfg_data
);

  logic [CH_W-1:0]          source_select;
  logic signed [TEMP_W-1:0] setpoint;
  logic [PRESCALE_W-1:0]    tick_prescale;
  logic [PRESCALE_W-1:0]    tick_prescale_next;
  logic                     age_step;
  logic                     p_valid;
  logic signed [TEMP_W-1:0] p_fallback;
  logic                     out_adv;
  logic                     accept;
  logic [CH_W-1:0]          sel;
  logic                     use_fb;
  logic                     out_of_range;
  cell_ctl_t                ctl;
  tap_t                     taps [NUM_SOURCES+1];

  assign cfg_ready = 1'b1;
  assign out_adv   = !rsp_valid || !rsp_stall;
  assign req_stall = p_valid && !out_adv;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_select <= '0;
      setpoint      <= SETPOINT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SOURCE_SELECT: source_select <= cfg_data[CH_W-1:0];
        CFG_SETPOINT:      setpoint      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    tick_prescale_next = tick_prescale + PRESCALE_W'(1);
    age_step           = 1'b0;
    if ({1'b0, tick_prescale_next} >= TICKS_PER_AGE || tick_prescale_next == '0) begin
      tick_prescale_next = '0;
      age_step           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_prescale <= '0;
    end else if (accept && req.req_type == REQ_TICK) begin
      tick_prescale <= tick_prescale_next;
    end
  end

  always_comb begin
    ctl.load     = accept && req.req_type == REQ_SAMPLE;
    ctl.channel  = req.channel;
    ctl.sample   = req.sample_temp;
    ctl.age_step = accept && req.req_type == REQ_TICK && age_step;
  end

  assign sel = ({1'b0, source_select} < (CH_W+1)'(NUM_SOURCES)) ? source_select : '0;

  assign taps[0] = '{value: '0, stale: 1'b1};

  for (genvar n = 0; n < NUM_SOURCES; n++) begin : g_cell
    satss_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (CH_W'(n)),
      .sel     (sel),
      .ctl     (ctl),
      .tap_in  (taps[n]),
      .tap_out (taps[n+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (out_adv) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_fallback <= req.fallback_temp;
    end
  end

  assign out_of_range = taps[NUM_SOURCES].value < TEMP_VALID_MIN ||
                        taps[NUM_SOURCES].value > TEMP_VALID_MAX;
  assign use_fb = sel == '0 || taps[NUM_SOURCES].stale || out_of_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_adv) begin
      rsp_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && p_valid) begin
      rsp.setpoint_out   <= setpoint;
      rsp.reference_temp <= use_fb ? p_fallback : taps[NUM_SOURCES].value;
      rsp.used_fallback  <= use_fb;
    end
  end

  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> p_valid && rsp_valid)
    else $error("request stalled with nothing pending");

  a_accept_pending: assert property (@(posedge clk) disable iff (rst)
    accept |=> p_valid)
    else $error("accepted item not pending");

  a_prescale_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, tick_prescale} < TICKS_PER_AGE)
    else $error("prescaler out of bound");

  a_ref_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.used_fallback |->
      rsp.reference_temp >= TEMP_VALID_MIN && rsp.reference_temp <= TEMP_VALID_MAX)
    else $error("channel value returned out of range");

endmodule
`default_nettype wire

// File: tb/sv/stale_aware_temperature_source_select_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for stale_aware_temperature_source_select.
// Predicts setpoint and reference temperature per item and checks them in order.
// Depends on satss_pkg and the top-level RTL.
module stale_aware_temperature_source_select_tb;
  import satss_pkg::*;

  localparam longint CYCLE_LIMIT = 1000000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = CFG_IDX_W'(3);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_item = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TEMP_W-1:0] cfg_data = '0;

  req_t pending_reqs[$];
  rsp_t expected_refs[$];
  bit req_taken = 1'b0;
  bit no_idle = 1'b0;
  int req_gap = 0;
  int stall_left = 0;
  int error_count = 0;
  longint cycle_count = 0;

  logic signed [TEMP_W-1:0] chan_temp [NUM_SOURCES];
  logic [AGE_W-1:0] chan_age [NUM_SOURCES];
  logic [PRESCALE_W-1:0] age_prescale;
  logic [CH_W-1:0] sel_setting;
  logic [TEMP_W-1:0] setpoint_setting;

  logic [CH_W-1:0] sel_plan [8] = '{4'd1, 4'd7, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2};

  stale_aware_temperature_source_select dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic rsp_t select_reference(input req_t item);
    rsp_t res;
    logic [CH_W-1:0] sel;
    int level;
    logic fb;
    if (item.req_type == REQ_SAMPLE) begin
      if (item.channel < NUM_SOURCES) begin
        chan_temp[item.channel] = item.sample_temp;
        chan_age[item.channel] = '0;
      end
    end else begin
      age_prescale = age_prescale + 1'b1;
      if (age_prescale >= TICKS_PER_AGE || age_prescale == '0) begin
        age_prescale = '0;
        for (int n = 0; n < NUM_SOURCES; n++)
          if (chan_age[n] <= MAX_AGE) chan_age[n] = chan_age[n] + 1'b1;
      end
    end
    sel = (sel_setting < NUM_SOURCES) ? sel_setting : '0;
    if (sel == '0) begin
      fb = 1'b1;
    end else begin
      level = chan_temp[sel];
      fb = (chan_age[sel] > MAX_AGE) || (level < TEMP_VALID_MIN) || (level > TEMP_VALID_MAX);
    end
    res.setpoint_out = setpoint_setting;
    res.reference_temp = fb ? item.fallback_temp : chan_temp[sel];
    res.used_fallback = fb;
    return res;
  endfunction

  function automatic req_t make_tick(input int fb);
    req_t item;
    item.req_type = REQ_TICK;
    item.channel = CH_W'($urandom);
    item.sample_temp = TEMP_W'($urandom);
    item.fallback_temp = TEMP_W'(fb);
    return item;
  endfunction

  function automatic req_t make_sample(input int ch, input int t, input int fb);
    req_t item;
    item.req_type = REQ_SAMPLE;
    item.channel = CH_W'(ch);
    item.sample_temp = TEMP_W'(t);
    item.fallback_temp = TEMP_W'(fb);
    return item;
  endfunction

  function automatic int pick_temp();
    int r;
    r = $urandom_range(99);
    if (r < 55) return int'($urandom_range(6500)) - 1000;
    if (r < 70) begin
      case ($urandom_range(3))
        0: return -1001;
        1: return -1000;
        2: return 5500;
        default: return 5501;
      endcase
    end
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TEMP_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SOURCE_SELECT: sel_setting = data[CH_W-1:0];
      CFG_SETPOINT: setpoint_setting = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || req_valid || expected_refs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : req_monitor
    if (!rst && req_valid && !req_stall) begin
      expected_refs.push_back(select_reference(req_item));
      req_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : req_driver
    logic next_valid;
    req_t next_item;
    next_valid = req_valid;
    next_item = req_item;
    if (!rst) begin
      if (req_taken) next_valid = 1'b0;
      req_taken = 1'b0;
      if (!next_valid) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (pending_reqs.size() != 0) begin
          next_item = pending_reqs.pop_front();
          next_valid = 1'b1;
          req_gap = pick_gap();
        end
      end
    end
    req_valid <= next_valid;
    req_item <= next_item;
  end

  always @(negedge clk) begin : rsp_stall_driver
    int r;
    if (stall_left == 0 && !no_idle) begin
      r = $urandom_range(99);
      if (r >= 75) stall_left = (r >= 96) ? $urandom_range(30, 10) : $urandom_range(3, 1);
    end
    if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : rsp_monitor
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_refs.size() == 0) begin
        $display("%0t: unexpected item setpoint_out=%0d reference_temp=%0d used_fallback=%0b",
                 $time, rsp_item.setpoint_out, rsp_item.reference_temp, rsp_item.used_fallback);
        error_count++;
      end else begin
        want = expected_refs.pop_front();
        if (rsp_item.setpoint_out !== want.setpoint_out) begin
          $display("%0t: setpoint_out expected %0d got %0d",
                   $time, want.setpoint_out, rsp_item.setpoint_out);
          error_count++;
        end
        if (rsp_item.reference_temp !== want.reference_temp) begin
          $display("%0t: reference_temp expected %0d got %0d",
                   $time, want.reference_temp, rsp_item.reference_temp);
          error_count++;
        end
        if (rsp_item.used_fallback !== want.used_fallback) begin
          $display("%0t: used_fallback expected %0b got %0b",
                   $time, want.used_fallback, rsp_item.used_fallback);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int r;
    logic [CH_W-1:0] focus;
    for (int n = 0; n < NUM_SOURCES; n++) begin
      chan_temp[n] = '0;
      chan_age[n] = AGE_STALE;
    end
    age_prescale = '0;
    sel_setting = '0;
    setpoint_setting = SETPOINT_RESET;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    pending_reqs.push_back(make_tick(-32768));
    pending_reqs.push_back(make_tick(32767));
    pending_reqs.push_back(make_sample(0, 2000, 16'h5555));
    pending_reqs.push_back(make_sample(15, 1234, -1));
    pending_reqs.push_back(make_sample(7, -32768, 100));
    wait_idle();
    write_reg(CFG_SOURCE_SELECT, {12'hFFF, 4'd7});
    write_reg(CFG_SETPOINT, 16'h8000);
    write_reg(CFG_UNMAPPED_LO, 16'hFFFF);
    write_reg(CFG_UNMAPPED_HI, 16'hAAAA);
    pending_reqs.push_back(make_tick(1));
    pending_reqs.push_back(make_sample(7, 5500, 2));
    pending_reqs.push_back(make_sample(7, 5501, 3));
    pending_reqs.push_back(make_sample(7, -1000, 4));
    pending_reqs.push_back(make_sample(7, -1001, 5));
    pending_reqs.push_back(make_sample(7, 32767, 6));
    pending_reqs.push_back(make_sample(7, 0, 7));
    pending_reqs.push_back(make_sample(3, 4000, 8));
    pending_reqs.push_back(make_sample(8, 77, 9));
    wait_idle();
    write_reg(CFG_SOURCE_SELECT, 16'd5);
    pending_reqs.push_back(make_tick(321));
    pending_reqs.push_back(make_sample(5, 2500, 322));
    wait_idle();
    write_reg(CFG_SOURCE_SELECT, 16'd15);
    pending_reqs.push_back(make_sample(7, 100, -32768));
    pending_reqs.push_back(make_tick(32767));
    wait_idle();
    write_reg(CFG_SOURCE_SELECT, 16'd8);
    pending_reqs.push_back(make_tick(-5));
    wait_idle();
    write_reg(CFG_SOURCE_SELECT, 16'd0);
    write_reg(CFG_SETPOINT, 16'h7FFF);
    pending_reqs.push_back(make_sample(0, 100, 55));
    wait_idle();

    // run the prescaler through several aging steps with no idle cycles
    write_reg(CFG_SOURCE_SELECT, 16'd2);
    no_idle = 1'b1;
    pending_reqs.push_back(make_sample(2, 1500, 0));
    pending_reqs.push_back(make_sample(1, -500, 0));
    for (int i = 0; i < 300; i++) begin
      if ($urandom_range(49) == 0)
        pending_reqs.push_back(make_sample($urandom_range(7, 3), pick_temp(), pick_temp()));
      else
        pending_reqs.push_back(make_tick(pick_temp()));
    end
    wait_idle();
    no_idle = 1'b0;

    for (int phase = 0; phase < 8; phase++) begin
      write_reg(CFG_SOURCE_SELECT, {12'($urandom), sel_plan[phase]});
      if (phase == 0) write_reg(CFG_SETPOINT, 16'h8000);
      else if (phase == 1) write_reg(CFG_SETPOINT, 16'h7FFF);
      else write_reg(CFG_SETPOINT, 16'($urandom));
      no_idle = (phase % 3 == 1);
      focus = sel_plan[phase];
      for (int i = 0; i < 172; i++) begin
        r = $urandom_range(99);
        if (r < 55)
          pending_reqs.push_back(make_tick(pick_temp()));
        else if (r < 80)
          pending_reqs.push_back(make_sample(int'(focus), pick_temp(), pick_temp()));
        else
          pending_reqs.push_back(make_sample(int'($urandom_range(15)), pick_temp(),
                                             pick_temp()));
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
